// ===== design/ttd_pkg.sv =====
package ttd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLIPPED    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_MAX_MS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REARM_MS   = 3'd4;

    localparam logic [7:0]  MOVE_LIMIT_RESET = 8'd12;
    localparam logic [15:0] TAP_MAX_RESET    = 16'd600;
    localparam logic [15:0] REARM_RESET      = 16'd250;

    localparam logic [3:0]  COORD_NIBBLE = 4'hF;
    localparam logic [11:0] RAW_LIMIT    = 12'd260;
    localparam logic [11:0] PANEL_MAX    = 12'd239;

    localparam logic [1:0] CONTACT_IDLE  = 2'd0;
    localparam logic [1:0] CONTACT_TOUCH = 2'd1;
    localparam logic [1:0] CONTACT_ERROR = 2'd2;

    typedef struct packed {
        logic        read_ok;
        logic [7:0]  fingers;
        logic [7:0]  x_high;
        logic [7:0]  x_low;
        logic [7:0]  y_high;
        logic [7:0]  y_low;
        logic [31:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic [1:0] contact;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       tap;
    } result_t;

    function automatic logic [7:0] make_pos(input logic [11:0] raw, input logic flip);
        logic [11:0] mirrored;
        logic [7:0]  pos;
        mirrored = PANEL_MAX - raw;
        if (flip)
        begin
            pos = (raw > PANEL_MAX) ? PANEL_MAX[7:0] : raw[7:0];
        end
        else
        begin
            pos = (raw > PANEL_MAX) ? 8'd0 : mirrored[7:0];
        end
        return pos;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== design/touch_tap_detector.sv =====
// A result appears in the output register in the cycle after its poll is accepted.
// Throughput: one poll per cycle; poll_ready drops only while a result waits unread.
// The path from the input to the result register is one 32-bit subtract and compare.
// Reset (rst_n, asynchronous, active low) restores register defaults, arms the
// detector and clears gesture state and the output valid.
module touch_tap_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            poll_valid,
    output logic                            poll_ready,
    input  ttd_pkg::poll_t                  poll,
    output logic                            result_valid,
    input  logic                            result_ready,
    output ttd_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [ttd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ttd_pkg::*;

    logic        enabled_reg;
    logic        flipped_reg;
    logic [7:0]  move_limit_reg;
    logic [15:0] tap_max_reg;
    logic [15:0] rearm_reg;

    logic        finger_down_reg, finger_down_next;
    logic [7:0]  start_x_reg, start_x_next;
    logic [7:0]  start_y_reg, start_y_next;
    logic [31:0] down_time_reg, down_time_next;
    logic        moved_reg, moved_next;
    logic        armed_reg, armed_next;
    logic [31:0] absent_time_reg, absent_time_next;
    logic        absent_known_reg, absent_known_next;

    logic        result_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;
    logic [11:0] raw_x, raw_y;
    logic [7:0]  px, py;
    logic        bad;
    logic [31:0] held_time;
    logic [31:0] absent_ref;
    logic [31:0] absent_span;
    logic        tap_hit;
    logic        armed_after;

    assign poll_ready   = !result_valid_reg || result_ready;
    assign accept       = poll_valid && poll_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign raw_x = {poll.x_high[3:0] & COORD_NIBBLE, poll.x_low};
    assign raw_y = {poll.y_high[3:0] & COORD_NIBBLE, poll.y_low};
    assign px    = make_pos(raw_x, flipped_reg);
    assign py    = make_pos(raw_y, flipped_reg);

    assign held_time   = poll.now_ms - down_time_reg;
    assign absent_ref  = (finger_down_reg || !absent_known_reg) ? poll.now_ms : absent_time_reg;
    assign absent_span = poll.now_ms - absent_ref;
    assign tap_hit     = !moved_reg && (held_time < {16'd0, tap_max_reg});
    assign armed_after = armed_reg && !finger_down_reg;

    always_comb
    begin
        bad = !enabled_reg || !poll.read_ok || (poll.fingers > 8'd1) ||
              ((poll.fingers == 8'd1) && ((raw_x > RAW_LIMIT) || (raw_y > RAW_LIMIT)));

        finger_down_next  = finger_down_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        down_time_next    = down_time_reg;
        moved_next        = moved_reg;
        armed_next        = armed_reg;
        absent_time_next  = absent_time_reg;
        absent_known_next = absent_known_reg;

        result_next.contact = CONTACT_ERROR;
        result_next.pos_x   = 8'd0;
        result_next.pos_y   = 8'd0;
        result_next.tap     = 1'b0;

        if (!bad)
        begin
            if (poll.fingers == 8'd1)
            begin
                absent_known_next   = 1'b0;
                result_next.contact = CONTACT_TOUCH;
                result_next.pos_x   = px;
                result_next.pos_y   = py;
                if (!finger_down_reg && armed_reg)
                begin
                    finger_down_next = 1'b1;
                    start_x_next     = px;
                    start_y_next     = py;
                    down_time_next   = poll.now_ms;
                    moved_next       = 1'b0;
                end
                else if (finger_down_reg)
                begin
                    if ((abs_diff(px, start_x_reg) > move_limit_reg) ||
                        (abs_diff(py, start_y_reg) > move_limit_reg))
                    begin
                        moved_next = 1'b1;
                    end
                end
            end
            else
            begin
                result_next.contact = CONTACT_IDLE;
                result_next.tap     = finger_down_reg && tap_hit;
                finger_down_next    = 1'b0;
                if (!armed_after)
                begin
                    absent_time_next  = absent_ref;
                    absent_known_next = 1'b1;
                    armed_next        = (absent_span >= {16'd0, rearm_reg});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            flipped_reg    <= 1'b0;
            move_limit_reg <= MOVE_LIMIT_RESET;
            tap_max_reg    <= TAP_MAX_RESET;
            rearm_reg      <= REARM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:    enabled_reg    <= cfg_data[0];
                REG_FLIPPED:    flipped_reg    <= cfg_data[0];
                REG_MOVE_LIMIT: move_limit_reg <= cfg_data[7:0];
                REG_TAP_MAX_MS: tap_max_reg    <= cfg_data;
                REG_REARM_MS:   rearm_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_down_reg  <= 1'b0;
            start_x_reg      <= 8'd0;
            start_y_reg      <= 8'd0;
            down_time_reg    <= 32'd0;
            moved_reg        <= 1'b0;
            armed_reg        <= 1'b1;
            absent_time_reg  <= 32'd0;
            absent_known_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                finger_down_reg  <= finger_down_next;
                start_x_reg      <= start_x_next;
                start_y_reg      <= start_y_next;
                down_time_reg    <= down_time_next;
                moved_reg        <= moved_next;
                armed_reg        <= armed_next;
                absent_time_reg  <= absent_time_next;
                absent_known_reg <= absent_known_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result register until a new transaction replaces it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_tap_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.tap |-> result_reg.contact == CONTACT_IDLE)
        else $error("tap reported without release");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.contact != CONTACT_TOUCH |->
            result_reg.pos_x == 8'd0 && result_reg.pos_y == 8'd0)
        else $error("position set without contact");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.contact == CONTACT_TOUCH |->
            result_reg.pos_x <= PANEL_MAX[7:0] && result_reg.pos_y <= PANEL_MAX[7:0])
        else $error("position out of panel range");

    a_down_armed: assert property (@(posedge clk) disable iff (!rst_n)
        finger_down_reg |-> armed_reg)
        else $error("gesture active while disarmed");

    a_disabled_error: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !enabled_reg |=> result_valid_reg && result_reg.contact == CONTACT_ERROR)
        else $error("disabled poll not reported as error");
`endif

endmodule
